// ----- sv/q4gemv_pkg.sv -----
// shared types, codes and decode functions for the q4 block gemv
package q4gemv_pkg;

   localparam int MAX_COLS_DEF = 4096;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   localparam logic [1:0] REG_BLOCKS = 2'd0;
   localparam logic [1:0] REG_FORMAT = 2'd1;
   localparam logic [1:0] REG_BIAS   = 2'd2;

   localparam logic [1:0] FMT_BF16 = 2'd0;
   localparam logic [1:0] FMT_FP8  = 2'd1;

   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

   typedef enum logic {FP_MUL, FP_ADD} fp_op_type;

   typedef struct packed {
      logic        start;
      fp_op_type   op;
      logic [31:0] a;
      logic [31:0] b;
   } fp_req_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_MULW, ST_MULX, ST_ADD, ST_BIAS, ST_OUT
   } state_type;

   // mantissa bits of 2^(i/8)
   function automatic logic [22:0] frac_pow2(input logic [2:0] i);
      logic [31:0] f;
      unique case (i)
         3'd0: f = 32'h3F80_0000;
         3'd1: f = 32'h3F8B_95C2;
         3'd2: f = 32'h3F98_37F0;
         3'd3: f = 32'h3FA5_FED7;
         3'd4: f = 32'h3FB5_04F3;
         3'd5: f = 32'h3FC5_672A;
         3'd6: f = 32'h3FD7_44FD;
         3'd7: f = 32'h3FEA_C0C7;
         default: f = 32'h3F80_0000;
      endcase
      return f[22:0];
   endfunction

   function automatic logic [31:0] decode_scale(input logic [1:0] fmt,
                                                input logic [15:0] code);
      logic [31:0] r;
      logic [7:0]  k;
      logic [7:0]  ip;
      r  = 32'h0;
      k  = code[7:0] - 8'd128;
      ip = {{3{k[7]}}, k[7:3]};
      priority if (fmt == FMT_BF16) begin
         r = {code, 16'h0};
      end else if (fmt == FMT_FP8) begin
         if (code[6:3] == 4'd0) begin
            r = {code[7], 31'h0};
         end else begin
            r = {code[7], {4'b0, code[6:3]} + 8'd120, code[2:0], 20'h0};
         end
      end else begin
         r = {1'b0, ip + 8'd127, frac_pow2(k[2:0])};
      end
      return r;
   endfunction

   function automatic logic [31:0] int4_to_float(input logic [3:0] n);
      logic [31:0] r;
      unique case (n)
         4'd0:  r = 32'h0000_0000;
         4'd1:  r = 32'h3F80_0000;
         4'd2:  r = 32'h4000_0000;
         4'd3:  r = 32'h4040_0000;
         4'd4:  r = 32'h4080_0000;
         4'd5:  r = 32'h40A0_0000;
         4'd6:  r = 32'h40C0_0000;
         4'd7:  r = 32'h40E0_0000;
         4'd8:  r = 32'hC100_0000;
         4'd9:  r = 32'hC0E0_0000;
         4'd10: r = 32'hC0C0_0000;
         4'd11: r = 32'hC0A0_0000;
         4'd12: r = 32'hC080_0000;
         4'd13: r = 32'hC040_0000;
         4'd14: r = 32'hC000_0000;
         4'd15: r = 32'hBF80_0000;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/q4gemv_if.sv -----
// request and result channel interfaces
interface q4gemv_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [11:0] x_index;
   logic [31:0] x_value;
   logic [63:0] weight_bytes;
   logic [15:0] scale_code;
   logic [15:0] bias_bits;
   modport source (output valid, command, x_index, x_value, weight_bytes, scale_code,
                   bias_bits, input ready);
   modport sink (input valid, command, x_index, x_value, weight_bytes, scale_code,
                 bias_bits, output ready);
endinterface

interface q4gemv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_value;
   logic [15:0] row_number;
   modport source (output valid, row_value, row_number, input ready);
   modport sink (input valid, row_value, row_number, output ready);
endinterface

// ----- sv/q4gemv_ram.sv -----
// generic simple dual-port ram with registered read
module q4gemv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ----- sv/q4gemv_fpu.sv -----
// shared two-stage float32 multiply / add unit, round to nearest even
module q4gemv_fpu (
   input  logic                   clock,
   input  logic                   reset,
   input  q4gemv_pkg::fp_req_type fp_req,
   output logic                   done,
   output logic [31:0]            result
);
   import q4gemv_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic               spec_ff, spec_in;
   logic [31:0]        spec_val_ff, spec_val_in;
   logic               sign_ff, sign_in;
   logic [56:0]        sig_ff, sig_in;
   logic signed [11:0] x_ff, x_in;
   logic               done_ff;
   logic [31:0]        result_ff, result_in;

   // stage 1: specials, exact product or aligned sum
   always_comb begin
      logic [31:0] a, b, big, sml;
      logic [23:0] siga, sigb, sigbig, sigsml;
      logic [8:0]  eea, eeb, eebig, eesml, d;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      logic [56:0] abig, bsml;
      logic [47:0] prod;
      a = fp_req.a;
      b = fp_req.b;
      siga = {a[30:23] != 8'd0, a[22:0]};
      sigb = {b[30:23] != 8'd0, b[22:0]};
      eea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
      eeb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
      nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = a[30:0] == 31'd0;
      zero_b = b[30:0] == 31'd0;
      big = (b[30:0] > a[30:0]) ? b : a;
      sml = (b[30:0] > a[30:0]) ? a : b;
      sigbig = {big[30:23] != 8'd0, big[22:0]};
      sigsml = {sml[30:23] != 8'd0, sml[22:0]};
      eebig = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
      eesml = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
      d = eebig - eesml;
      abig = {1'b0, sigbig, 32'h0};
      // far-off operand collapses into a sticky bit
      bsml = (d > 9'd31) ? {56'h0, sigsml != 24'd0} : ({1'b0, sigsml, 32'h0} >> d);
      prod = siga * sigb;
      spec_in = 1'b0;
      spec_val_in = 32'h0;
      if (nan_a) begin
         spec_in = 1'b1;
         spec_val_in = a | FP_QUIET_BIT;
      end else if (nan_b) begin
         spec_in = 1'b1;
         spec_val_in = b | FP_QUIET_BIT;
      end
      if (fp_req.op == FP_MUL) begin
         sign_in = a[31] ^ b[31];
         sig_in = {9'h0, prod};
         x_in = 12'(eea) + 12'(eeb) - 12'd300;
         if (!nan_a && !nan_b) begin
            if ((inf_a && zero_b) || (inf_b && zero_a)) begin
               spec_in = 1'b1;
               spec_val_in = FP_DEFAULT_NAN;
            end else if (inf_a || inf_b) begin
               spec_in = 1'b1;
               spec_val_in = {sign_in, 8'hFF, 23'h0};
            end
         end
      end else begin
         sig_in = (big[31] == sml[31]) ? abig + bsml : abig - bsml;
         sign_in = (sig_in == 57'd0) ? (a[31] & b[31]) : big[31];
         x_in = 12'(eebig) - 12'd182;
         if (!nan_a && !nan_b) begin
            if (inf_a && inf_b && (a[31] != b[31])) begin
               spec_in = 1'b1;
               spec_val_in = FP_DEFAULT_NAN;
            end else if (inf_a) begin
               spec_in = 1'b1;
               spec_val_in = a;
            end else if (inf_b) begin
               spec_in = 1'b1;
               spec_val_in = b;
            end
         end
      end
      s1_valid_in = fp_req.start;
   end

   // stage 2: normalize and round
   always_comb begin
      logic [5:0]         p;
      logic signed [11:0] sh_a, sh_b, sh, e, field;
      logic [6:0]         shr;
      logic [114:0]       t;
      logic [56:0]        lsh;
      logic [24:0]        mant, m2;
      logic               g, st, up;
      p = 6'd0;
      for (int i = 0; i < 57; i++) begin
         if (sig_ff[i]) begin
            p = 6'(i);
         end
      end
      sh_a = $signed({6'b0, p}) - 12'sd23;
      sh_b = -12'sd149 - x_ff;
      sh = (sh_a > sh_b) ? sh_a : sh_b;
      t = 115'h0;
      lsh = 57'h0;
      shr = 7'd0;
      g = 1'b0;
      st = 1'b0;
      if (sh <= 12'sd0) begin
         lsh = sig_ff << 6'(-sh);
         mant = {1'b0, lsh[23:0]};
      end else begin
         shr = (sh > 12'sd58) ? 7'd58 : 7'(sh);
         t = {sig_ff, 58'h0} >> shr;
         mant = 25'(t[114:58]);
         g = t[57];
         st = t[56:0] != 57'h0;
      end
      up = g & (st | mant[0]);
      m2 = mant + 25'(up);
      e = sh + x_ff;
      if (m2[24]) begin
         m2 = m2 >> 1;
         e = e + 12'sd1;
      end
      field = m2[23] ? (e + 12'sd150) : 12'sd0;
      if (spec_ff) begin
         result_in = spec_val_ff;
      end else if (sig_ff == 57'd0) begin
         result_in = {sign_ff, 31'h0};
      end else if (field >= 12'sd255) begin
         result_in = {sign_ff, 8'hFF, 23'h0};
      end else begin
         result_in = {sign_ff, field[7:0], m2[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         done_ff <= s1_valid_ff;
      end
      spec_ff <= spec_in;
      spec_val_ff <= spec_val_in;
      sign_ff <= sign_in;
      sig_ff <= sig_in;
      x_ff <= x_in;
      if (s1_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign done = done_ff;
   assign result = result_ff;
endmodule

// ----- sv/q4_block_quantized_gemv.sv -----
// q4 block-quantized matrix-vector multiply, top level and sequencer
//
//  channel | dir | beat contents
//  req     | in  | command, x_index, x_value, weight_bytes, scale_code, bias_bits
//  rsp     | out | row_value, row_number
//  csr     | in  | apb writes of blocks_per_row, scale_format, bias_enable
//
// a load beat is taken while idle; each of the 16 columns of a weight beat goes through
// fetch, two multiplies and an add; the last half-block of a row adds the bias, if on,
// and hands off the row. each column needs three float ops through the one float unit.
// reset is synchronous and clears control state; the vector store is not cleared.
// a finished row waits in the output register while the next beat is taken.
module q4_block_quantized_gemv #(
   parameter int MAX_COLS = q4gemv_pkg::MAX_COLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   q4gemv_req_if.sink          req,
   q4gemv_rsp_if.source        rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import q4gemv_pkg::*;

   localparam int AW = $clog2(MAX_COLS);

   state_type   state_ff, state_in;
   logic [8:0]  hbp_ff, hbp_in;
   logic [3:0]  j_ff, j_in;
   logic [AW-1:0] col_ff, col_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] scale_ff, scale_in;
   logic [63:0] wbytes_ff, wbytes_in;
   logic [15:0] bias_ff, bias_in;
   logic [15:0] row_ff, row_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [15:0] rsp_row_ff, rsp_row_in;
   logic [7:0]  blocks_ff;
   logic [1:0]  format_ff;
   logic        bias_en_ff;

   fp_req_type  fp_req;
   logic        fp_done;
   logic [31:0] fp_result;
   logic        ram_wr_en, ram_rd_en;
   logic [31:0] ram_rd_data;
   logic        is_last;
   logic [9:0]  last_pos;
   logic        accept;
   logic        cfg_write;

   q4gemv_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .fp_req (fp_req),
      .done   (fp_done),
      .result (fp_result)
   );

   q4gemv_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req.x_index)),
      .wr_data (req.x_value),
      .rd_en   (ram_rd_en),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign accept = req.valid && req.ready;
   assign last_pos = (blocks_ff == 8'd0) ? 10'd1 : {1'b0, blocks_ff, 1'b0} - 10'd1;
   assign is_last = {1'b0, hbp_ff} >= last_pos;
   assign ram_wr_en = accept && (req.command == CMD_LOAD)
                      && ({20'h0, req.x_index} < 32'(MAX_COLS));

   always_comb begin
      state_in = state_ff;
      hbp_in = hbp_ff;
      j_in = j_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      scale_in = scale_ff;
      wbytes_in = wbytes_ff;
      bias_in = bias_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in = rsp_row_ff;
      fp_req = '{start: 1'b0, op: FP_MUL, a: scale_ff,
                 b: int4_to_float(4'(wbytes_ff >> {j_ff, 2'b00}))};
      ram_rd_en = 1'b0;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid && (req.command == CMD_WEIGHT)) begin
               wbytes_in = req.weight_bytes;
               bias_in = req.bias_bits;
               if (!hbp_ff[0]) begin
                  scale_in = decode_scale(format_ff, req.scale_code);
               end
               j_in = 4'd0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            fp_req.start = 1'b1;
            state_in = ST_MULW;
         end
         ST_MULW: begin
            if (fp_done) begin
               fp_req = '{start: 1'b1, op: FP_MUL, a: fp_result, b: ram_rd_data};
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            if (fp_done) begin
               fp_req = '{start: 1'b1, op: FP_ADD, a: acc_ff, b: fp_result};
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fp_done) begin
               acc_in = fp_result;
               col_in = (col_ff == AW'(MAX_COLS - 1)) ? '0 : col_ff + 1'b1;
               j_in = j_ff + 4'd1;
               if (j_ff != 4'd15) begin
                  state_in = ST_FETCH;
               end else if (!is_last) begin
                  hbp_in = hbp_ff + 9'd1;
                  state_in = ST_IDLE;
               end else if (bias_en_ff) begin
                  fp_req = '{start: 1'b1, op: FP_ADD, a: fp_result, b: {bias_ff, 16'h0}};
                  state_in = ST_BIAS;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_BIAS: begin
            if (fp_done) begin
               acc_in = fp_result;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               rsp_row_in = row_ff;
               row_in = row_ff + 16'd1;
               acc_in = 32'h0;
               hbp_in = 9'd0;
               col_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hbp_ff <= 9'd0;
         col_ff <= '0;
         acc_ff <= 32'h0;
         scale_ff <= 32'h0;
         row_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hbp_ff <= hbp_in;
         col_ff <= col_in;
         acc_ff <= acc_in;
         scale_ff <= scale_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff <= j_in;
      wbytes_ff <= wbytes_in;
      bias_ff <= bias_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff <= rsp_row_in;
   end

   // configuration registers
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= 8'd1;
         format_ff <= FMT_BF16;
         bias_en_ff <= 1'b0;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_BLOCKS: blocks_ff <= csr_pwdata[7:0];
            REG_FORMAT: format_ff <= csr_pwdata[1:0];
            REG_BIAS:   bias_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BLOCKS: csr_prdata = {24'h0, blocks_ff};
         REG_FORMAT: csr_prdata = {30'h0, format_ff};
         REG_BIAS:   csr_prdata = {31'h0, bias_en_ff};
         default:    csr_prdata = 32'h0;
      endcase
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.row_value = rsp_value_ff;
   assign rsp.row_number = rsp_row_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fp_done |-> (state_ff == ST_MULW || state_ff == ST_MULX
                   || state_ff == ST_ADD || state_ff == ST_BIAS))
      else $error("float unit finished outside a wait state");

   a_weight_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == CMD_WEIGHT) |=> !req.ready)
      else $error("ready stayed high after a weight beat");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the hand-off state");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(MAX_COLS))
      else $error("column counter beyond the store");
endmodule

// ----- verif/q4gemv_checker.sv -----
// watches the q4 gemv channels, predicts each finished row and compares it
module q4gemv_checker (
   input  logic        clock,
   input  logic        reset,
   q4gemv_req_if       req,
   q4gemv_rsp_if       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatches,
   output int          rows_waiting,
   output int          rows_checked
);
   import q4gemv_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [15:0] number;
   } row_result_type;

   logic [31:0] x_store [0:MAX_COLS_DEF-1];
   logic [31:0] acc_bits;
   logic [31:0] scale_bits;
   int unsigned half_pos;
   logic [15:0] row_num;
   logic [7:0]  blocks_cfg;
   logic [1:0]  format_cfg;
   logic        bias_cfg;
   row_result_type expected_rows[$];

   // 2^(i/8) as written for the scale table
   real frac_pow2_val [0:7] = '{1.0, 1.0905077326652577, 1.1892071150027210,
      1.2968395546510096, 1.4142135623730951, 1.5422108254079407,
      1.6817928305074290, 1.8340080864093424};

   function automatic real single_to_real(input logic [31:0] f);
      logic [63:0] d;
      int p;
      d = {f[31], 63'b0};
      if (f[30:23] == 8'hFF) begin
         d = (f[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {f[31], 11'h7FF, 52'b0};
      end else if (f[30:23] != 0) begin
         d = {f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0};
      end else if (f[22:0] != 0) begin
         p = 22;
         while (!f[p]) p--;
         d = {f[31], 11'(p - 149 + 1023), 52'(({29'b0, f[22:0]} << (52 - p)))};
      end
      return $bitstoreal(d);
   endfunction

   // round a double to single, nearest even, subnormals kept
   function automatic logic [31:0] round_to_single(input real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] res;
      int fe;
      int shift;
      int base;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'b0};
      if (d[62:52] == 0)
         return {d[63], 31'b0};
      m = {11'b0, 1'b1, d[51:0]};
      fe = int'(d[62:52]) - 896;
      shift = (fe >= 1) ? 29 : 30 - fe;
      base = (fe >= 1) ? fe - 1 : 0;
      if (shift > 60)
         return {d[63], 31'b0};
      q = m >> shift;
      rem = m & ((64'd1 << shift) - 1);
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && q[0]))
         q = q + 1;
      res = (64'(base) << 23) + q;
      if (res >= 64'h7F80_0000)
         return {d[63], 8'hFF, 23'b0};
      return {d[63], res[30:0]};
   endfunction

   function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
      return round_to_single(single_to_real(a) * single_to_real(b));
   endfunction

   function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
      return round_to_single(single_to_real(a) + single_to_real(b));
   endfunction

   function automatic logic [31:0] block_scale(input logic [1:0] fmt, input logic [15:0] code);
      int k;
      int ip;
      int fr;
      if (fmt == FMT_BF16)
         return {code, 16'h0};
      if (fmt == FMT_FP8) begin
         if (code[6:3] == 4'd0)
            return {code[7], 31'b0};
         return {code[7], 8'(code[6:3] + 8'd120), code[2:0], 20'b0};
      end
      k = int'(code[7:0]) - 128;
      ip = (k >= 0) ? k / 8 : -((7 - k) / 8);
      fr = k - ip * 8;
      return round_to_single(frac_pow2_val[fr] * (2.0 ** ip));
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic predict_beat();
      int unsigned last;
      int unsigned col;
      int w;
      logic [3:0] nib;
      logic [31:0] sw;
      logic [31:0] v;
      if (req.command == CMD_LOAD) begin
         x_store[req.x_index] = req.x_value;
         return;
      end
      last = 2 * ((blocks_cfg != 0) ? blocks_cfg : 1) - 1;
      if (!half_pos[0])
         scale_bits = block_scale(format_cfg, req.scale_code);
      for (int j = 0; j < 16; j++) begin
         nib = req.weight_bytes[4*j +: 4];
         w = nib[3] ? int'(nib) - 16 : int'(nib);
         col = (half_pos * 16 + j) % MAX_COLS_DEF;
         sw = single_mul(scale_bits, round_to_single(real'(w)));
         acc_bits = single_add(acc_bits, single_mul(sw, x_store[col]));
      end
      if (half_pos >= last) begin
         v = acc_bits;
         if (bias_cfg)
            v = single_add(v, {req.bias_bits, 16'h0});
         expected_rows.push_back('{value: v, number: row_num});
         row_num++;
         acc_bits = 32'h0;
         half_pos = 0;
      end else begin
         half_pos++;
      end
   endtask

   task automatic check_row();
      row_result_type exp_row;
      logic nan_both;
      if (expected_rows.size() == 0) begin
         report_mismatch($sformatf("unexpected row %0d value %h",
                                   rsp.row_number, rsp.row_value));
         return;
      end
      exp_row = expected_rows.pop_front();
      rows_checked++;
      // any nan pattern is accepted where a nan is due
      nan_both = exp_row.value[30:23] == 8'hFF && exp_row.value[22:0] != 0 &&
                 rsp.row_value[30:23] == 8'hFF && rsp.row_value[22:0] != 0;
      if (rsp.row_value !== exp_row.value && !nan_both)
         report_mismatch($sformatf("row %0d value %h, expected %h",
                                   exp_row.number, rsp.row_value, exp_row.value));
      if (rsp.row_number !== exp_row.number)
         report_mismatch($sformatf("row number %0d, expected %0d",
                                   rsp.row_number, exp_row.number));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         acc_bits = 32'h0;
         scale_bits = 32'h0;
         half_pos = 0;
         row_num = 16'h0;
         blocks_cfg = 8'd1;
         format_cfg = FMT_BF16;
         bias_cfg = 1'b0;
         expected_rows.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BLOCKS: blocks_cfg = csr_pwdata[7:0];
               REG_FORMAT: format_cfg = csr_pwdata[1:0];
               REG_BIAS:   bias_cfg = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            predict_beat();
         if (rsp.valid && rsp.ready)
            check_row();
      end
      rows_waiting <= expected_rows.size();
   end

endmodule

// ----- verif/tb.sv -----
// stimulus, clock, reset and verdict for the q4 block gemv
module tb;
   import q4gemv_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 150;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatches;
   int          rows_waiting;
   int          rows_checked;
   int          gap_pct;
   int          stall_pct;
   int          idle_cycles;
   int          weight_beats;
   int          load_beats;
   logic        written [0:MAX_COLS_DEF-1];

   q4gemv_req_if req ();
   q4gemv_rsp_if rsp ();

   q4_block_quantized_gemv u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   q4gemv_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .mismatches(mismatches), .rows_waiting(rows_waiting), .rows_checked(rows_checked)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock)
      rsp.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("no progress for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [31:0] moderate_x();
      if ($urandom_range(99) < 5)
         return $urandom;
      return {1'($urandom), 8'(120 + $urandom_range(14)), 23'($urandom)};
   endfunction

   function automatic logic [15:0] random_scale();
      if ($urandom_range(99) < 20)
         return 16'($urandom);
      return {1'($urandom), 8'(118 + $urandom_range(16)), 7'($urandom)};
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_beat(input logic cmd, input logic [11:0] idx, input logic [31:0] xv,
                            input logic [63:0] wb, input logic [15:0] sc,
                            input logic [15:0] bias);
      if ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.x_index <= idx;
      req.x_value <= xv;
      req.weight_bytes <= wb;
      req.scale_code <= sc;
      req.bias_bits <= bias;
      do @(posedge clock); while (!req.ready);
      if (cmd == CMD_LOAD) begin
         written[idx] = 1'b1;
         load_beats++;
      end else begin
         weight_beats++;
      end
   endtask

   task automatic load_x(input logic [11:0] idx, input logic [31:0] xv);
      send_beat(CMD_LOAD, idx, xv, {$urandom, $urandom}, 16'($urandom), 16'($urandom));
   endtask

   task automatic weight(input logic [63:0] wb, input logic [15:0] sc,
                         input logic [15:0] bias);
      send_beat(CMD_WEIGHT, 12'($urandom), $urandom, wb, sc, bias);
   endtask

   // wait until every row is out and the block has had time to go idle
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (rows_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic setup(input logic [7:0] bpr, input logic [1:0] fmt, input logic bias_on);
      settle();
      csr_write(REG_BLOCKS, {24'b0, bpr});
      csr_write(REG_FORMAT, {30'b0, fmt});
      csr_write(REG_BIAS, {31'b0, bias_on});
      for (int c = 0; c < 32 * ((bpr != 0) ? bpr : 1); c++)
         if (!written[c]) load_x(12'(c), moderate_x());
   endtask

   task automatic random_rows(input logic [7:0] bpr, input int rows);
      for (int r = 0; r < rows; r++)
         for (int h = 0; h < 2 * bpr; h++) begin
            if ($urandom_range(99) < 15)
               load_x(12'($urandom_range(MAX_COLS_DEF - 1)), moderate_x());
            weight({$urandom, $urandom}, random_scale(), 16'($urandom));
         end
   endtask

   initial begin
      logic [7:0] bpr;
      int phase_beats;
      logic fail;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= 4'h0;
      csr_pwdata <= 32'h0;
      req.valid <= 1'b0;
      req.command <= CMD_LOAD;
      req.x_index <= 12'h0;
      req.x_value <= 32'h0;
      req.weight_bytes <= 64'h0;
      req.scale_code <= 16'h0;
      req.bias_bits <= 16'h0;
      gap_pct = 0;
      stall_pct = 0;
      weight_beats = 0;
      load_beats = 0;
      for (int c = 0; c < MAX_COLS_DEF; c++) written[c] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // index and value extremes, then a usable value over index zero
      load_x(12'd4095, 32'hFFFF_FFFF);
      load_x(12'd0, 32'h0000_0000);
      load_x(12'd0, 32'h3F80_0000);

      // bf16 scales: zero, nan, infinity, weight extremes, bias on
      setup(8'd1, FMT_BF16, 1'b1);
      weight({16{4'h8}}, 16'h3F80, 16'h0000);
      weight({16{4'h7}}, 16'h0000, 16'hFFFF);
      weight({16{4'hF}}, 16'hFFFF, 16'h0000);
      weight(64'h0, 16'h4000, 16'h3F80);
      weight(64'hFEDC_BA98_7654_3210, 16'h7F80, 16'h0000);
      weight({16{4'h1}}, 16'h8000, 16'h7F80);
      // fp8: zero exponent with both signs, exponent fifteen
      setup(8'd1, FMT_FP8, 1'b0);
      weight({16{4'h3}}, 16'hFF00, 16'h0);
      weight({16{4'h9}}, 16'h0080, 16'h0);
      weight({16{4'h5}}, 16'h007F, 16'h0);
      weight({16{4'hC}}, 16'h00FF, 16'h0);
      // log2 scale extremes, and format three decoded the same way
      setup(8'd1, 2'd2, 1'b0);
      weight({$urandom, $urandom}, 16'h0000, 16'h0);
      weight({$urandom, $urandom}, 16'h0080, 16'h0);
      weight({$urandom, $urandom}, 16'h00FF, 16'h0);
      weight({$urandom, $urandom}, 16'hFF81, 16'h0);
      setup(8'd1, 2'd3, 1'b1);
      weight({$urandom, $urandom}, 16'h0081, 16'hBF80);
      weight({$urandom, $urandom}, 16'h0037, 16'h4120);
      // zero row length acts as one block
      setup(8'd0, FMT_BF16, 1'b0);
      weight({$urandom, $urandom}, 16'h3E00, 16'h0);
      weight({$urandom, $urandom}, 16'h3E00, 16'h0);
      // row length cut while a row is open: the next beat ends the row
      setup(8'd2, FMT_BF16, 1'b1);
      weight({$urandom, $urandom}, 16'h3F00, 16'h0);
      weight({$urandom, $urandom}, 16'h3F00, 16'h0);
      weight({$urandom, $urandom}, 16'h3F40, 16'h0);
      settle();
      csr_write(REG_BLOCKS, 32'd1);
      weight({$urandom, $urandom}, 16'h4000, 16'h3F80);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 45; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 45; end
            default: begin gap_pct = 23; stall_pct = 23; end
         endcase
         phase_beats = weight_beats;
         while (weight_beats - phase_beats < 75) begin
            bpr = ($urandom_range(99) < 70) ? 8'($urandom_range(1, 4))
                                            : 8'($urandom_range(5, 16));
            setup(bpr, 2'($urandom_range(3)), 1'($urandom));
            random_rows(bpr, (bpr > 8) ? 1 : $urandom_range(1, 6));
         end
      end

      settle();
      $display("covered %0d weight beats and %0d vector loads, %0d rows compared",
               weight_beats, load_beats, rows_checked);
      fail = (mismatches != 0) || (rows_waiting != 0);
      if (rows_waiting != 0)
         $display("%0d expected rows never came out", rows_waiting);
      if (!fail) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
